// ----- rtl/round_robin_task_scheduler_defines.svh -----
// Assertion macros for the round robin task scheduler checker.
// Needs a clk and rst_n in the scope where the macros are used.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define RRTS_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("scheduler check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define RRTS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("scheduler check failed");

`endif

// ----- rtl/rrts_pkg.sv -----
// Shared types and constants for the round robin task scheduler.
// No dependencies; used by rrts_list and the top level.
`default_nettype none
package rrts_pkg;

    // MAX_PROCS must be a power of two: list addresses wrap in ID_W bits.
    localparam int MAX_PROCS = 32;
    localparam int ID_W      = $clog2(MAX_PROCS);
    localparam int LEN_W     = $clog2(MAX_PROCS + 1);
    localparam int QUANT_W   = 16;
    localparam int CNT32_W   = 32;

    typedef enum logic [1:0] {
        LOP_PUSH   = 2'd0,
        LOP_POP    = 2'd1,
        LOP_REMOVE = 2'd2
    } list_op_t;

    typedef struct packed {
        logic            valid;
        list_op_t        op;
        logic [ID_W-1:0] id;
    } list_cmd_t;

    typedef struct packed {
        logic             busy;
        logic [ID_W-1:0]  data;
        logic [LEN_W-1:0] len;
    } list_rsp_t;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_YIELD   = 3'd1,
        OP_READY   = 3'd2,
        OP_BLOCK   = 3'd3,
        OP_UNBLOCK = 3'd4
    } sched_op_t;

    localparam logic [2:0] REG_QUANTUM    = 3'd0;
    localparam logic [2:0] REG_PREEMPT    = 3'd1;
    localparam logic [2:0] REG_RUN        = 3'd2;
    localparam logic [2:0] REG_IDLE_ID    = 3'd3;
    localparam logic [2:0] REG_IDLE_VALID = 3'd4;

endpackage
`default_nettype wire

// ----- rtl/rrts_list.sv -----
// ID list in a one-port-read, one-port-write memory, kept as a ring.
// Push at tail, pop at head, remove first match by scan and compaction. Uses rrts_pkg.
`default_nettype none
module rrts_list (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rrts_pkg::list_cmd_t cmd,
    output rrts_pkg::list_rsp_t    rsp
);
    import rrts_pkg::*;

    typedef enum logic [5:0] {
        L_IDLE = 6'b000001,
        L_POP  = 6'b000010,
        L_SRD  = 6'b000100,
        L_SCHK = 6'b001000,
        L_MRD  = 6'b010000,
        L_MWR  = 6'b100000
    } lstate_t;

    logic [ID_W-1:0] mem [0:MAX_PROCS-1];
    logic [ID_W-1:0] rdata_reg;

    lstate_t          state_reg, state_next;
    logic [ID_W-1:0]  head_reg, head_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [ID_W-1:0]  tgt_reg, tgt_next;

    logic             re, we;
    logic [ID_W-1:0]  raddr, waddr, wdata;
    logic [LEN_W-1:0] cnt_inc;

    assign cnt_inc = cnt_reg + LEN_W'(1);

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        tgt_next   = tgt_reg;
        re         = 1'b0;
        we         = 1'b0;
        raddr      = head_reg;
        waddr      = head_reg;
        wdata      = cmd.id;
        unique case (state_reg)
            L_IDLE:
            begin
                if (cmd.valid)
                begin
                    unique case (cmd.op)
                        LOP_PUSH:
                        begin
                            // drop when full
                            if (len_reg != LEN_W'(MAX_PROCS))
                            begin
                                we       = 1'b1;
                                waddr    = head_reg + len_reg[ID_W-1:0];
                                len_next = len_reg + LEN_W'(1);
                            end
                        end
                        LOP_POP:
                        begin
                            re         = 1'b1;
                            state_next = L_POP;
                        end
                        LOP_REMOVE:
                        begin
                            if (len_reg != '0)
                            begin
                                cnt_next   = '0;
                                tgt_next   = cmd.id;
                                state_next = L_SRD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            L_POP:
            begin
                head_next  = head_reg + ID_W'(1);
                len_next   = len_reg - LEN_W'(1);
                state_next = L_IDLE;
            end
            L_SRD:
            begin
                re         = 1'b1;
                raddr      = head_reg + cnt_reg[ID_W-1:0];
                state_next = L_SCHK;
            end
            L_SCHK:
            begin
                if (rdata_reg == tgt_reg)
                    state_next = L_MRD;
                else if (cnt_inc == len_reg)
                    state_next = L_IDLE;
                else
                begin
                    cnt_next   = cnt_inc;
                    state_next = L_SRD;
                end
            end
            L_MRD:
            begin
                // close the gap one entry at a time
                if (cnt_inc == len_reg)
                begin
                    len_next   = len_reg - LEN_W'(1);
                    state_next = L_IDLE;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = head_reg + cnt_inc[ID_W-1:0];
                    state_next = L_MWR;
                end
            end
            L_MWR:
            begin
                we         = 1'b1;
                waddr      = head_reg + cnt_reg[ID_W-1:0];
                wdata      = rdata_reg;
                cnt_next   = cnt_inc;
                state_next = L_MRD;
            end
            default: state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            head_reg  <= '0;
            len_reg   <= '0;
            cnt_reg   <= '0;
            tgt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            tgt_reg   <= tgt_next;
        end
    end

    assign rsp.busy = (state_reg != L_IDLE);
    assign rsp.data = rdata_reg;
    assign rsp.len  = len_reg;

endmodule
`default_nettype wire

// ----- rtl/round_robin_task_scheduler.sv -----
// Round robin task scheduler: sequencer, configuration registers, result register.
// Depends on rrts_pkg and rrts_list (ready queue and blocked list).
//
// Usage:
//   s_axis carries one event request: tick, yield, make ready, block, unblock.
//   m_axis returns one result per request: running process, switch info,
//   queue occupancies, wrapping statistics and a drop flag.
//   The APB port writes and reads the five configuration registers; write only
//   while no request is in flight.
// Requests:
//   One request at a time. Block and unblock scan the list memory entry by
//   entry up to the match and move each entry behind it forward; the single
//   read port of each list memory paces this scan.
// Reset:
//   Lists empty, no process running, counters zero, registers at defaults.
// Stall:
//   A finished result waits in the output register; the next request is
//   taken meanwhile and its result holds until the receiver takes the first.
`default_nettype none
module round_robin_task_scheduler (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [2:0] operation, [7:3] process_id
    input  wire logic [7:0]   s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [4:0] current_id, [5] current_valid, [6] switched, [11:7] previous_id,
    // [12] previous_valid, [13] enter_user, [19:14] ready_count,
    // [25:20] blocked_count, [57:26] switch_total, [89:58] preempt_total,
    // [121:90] yield_total, [122] dropped, [127:123] zero
    output logic [127:0]      m_axis_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import rrts_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_EXEC  = 9'b000000010,
        S_BLK   = 9'b000000100,
        S_UNB   = 9'b000001000,
        S_SCHED = 9'b000010000,
        S_POPW  = 9'b000100000,
        S_SW    = 9'b001000000,
        S_OUT   = 9'b010000000,
        S_HOLD  = 9'b100000000
    } state_t;

    // configuration
    logic [QUANT_W-1:0] quantum_reg;
    logic               preempt_en_reg, run_en_reg, idle_valid_reg;
    logic [ID_W-1:0]    idle_id_reg;
    logic               cfg_wr;
    logic [2:0]         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg    <= QUANT_W'(10);
            preempt_en_reg <= 1'b1;
            run_en_reg     <= 1'b0;
            idle_id_reg    <= '0;
            idle_valid_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_QUANTUM:    quantum_reg    <= pwdata[QUANT_W-1:0];
                REG_PREEMPT:    preempt_en_reg <= pwdata[0];
                REG_RUN:        run_en_reg     <= pwdata[0];
                REG_IDLE_ID:    idle_id_reg    <= pwdata[ID_W-1:0];
                REG_IDLE_VALID: idle_valid_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_QUANTUM:    prdata = {{(32-QUANT_W){1'b0}}, quantum_reg};
            REG_PREEMPT:    prdata = {31'd0, preempt_en_reg};
            REG_RUN:        prdata = {31'd0, run_en_reg};
            REG_IDLE_ID:    prdata = {{(32-ID_W){1'b0}}, idle_id_reg};
            REG_IDLE_VALID: prdata = {31'd0, idle_valid_reg};
            default:        prdata = '0;
        endcase
    end

    // lists
    list_cmd_t rdy_cmd, blk_cmd;
    list_rsp_t rdy_rsp, blk_rsp;

    rrts_list u_ready (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (rdy_cmd),
        .rsp   (rdy_rsp)
    );

    rrts_list u_blocked (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (blk_cmd),
        .rsp   (blk_rsp)
    );

    // control state
    state_t               state_reg, state_next;
    logic [MAX_PROCS-1:0] sleep_reg, sleep_next;
    logic [ID_W-1:0]      run_id_reg, run_id_next;
    logic                 run_valid_reg, run_valid_next;
    logic [QUANT_W-1:0]   qleft_reg, qleft_next;
    logic [CNT32_W-1:0]   sw_cnt_reg, sw_cnt_next;
    logic [CNT32_W-1:0]   pre_cnt_reg, pre_cnt_next;
    logic [CNT32_W-1:0]   yld_cnt_reg, yld_cnt_next;
    logic                 ev_drop_reg, ev_drop_next;
    logic                 ev_sw_reg, ev_sw_next;
    logic                 ev_pv_reg, ev_pv_next;
    logic                 out_valid_reg, out_valid_next;

    // payload
    logic [2:0]           op_reg, op_next;
    logic [ID_W-1:0]      pid_reg, pid_next;
    logic [ID_W-1:0]      nxt_reg, nxt_next;
    logic [ID_W-1:0]      ev_pid_reg, ev_pid_next;
    logic [127:0]         out_data_reg, out_data_next;

    logic [QUANT_W-1:0]   qdec;
    logic                 in_acc;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign qdec          = (qleft_reg != '0) ? qleft_reg - QUANT_W'(1) : qleft_reg;

    always_comb
    begin
        state_next     = state_reg;
        sleep_next     = sleep_reg;
        run_id_next    = run_id_reg;
        run_valid_next = run_valid_reg;
        qleft_next     = qleft_reg;
        sw_cnt_next    = sw_cnt_reg;
        pre_cnt_next   = pre_cnt_reg;
        yld_cnt_next   = yld_cnt_reg;
        ev_drop_next   = ev_drop_reg;
        ev_sw_next     = ev_sw_reg;
        ev_pv_next     = ev_pv_reg;
        ev_pid_next    = ev_pid_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        pid_next       = pid_reg;
        nxt_next       = nxt_reg;
        out_data_next  = out_data_reg;
        rdy_cmd        = '{valid: 1'b0, op: LOP_PUSH, id: pid_reg};
        blk_cmd        = '{valid: 1'b0, op: LOP_PUSH, id: pid_reg};

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    op_next      = s_axis_tdata[2:0];
                    pid_next     = s_axis_tdata[7:3];
                    ev_drop_next = 1'b0;
                    ev_sw_next   = 1'b0;
                    ev_pv_next   = 1'b0;
                    ev_pid_next  = '0;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_OUT;
                unique case (op_reg)
                    OP_TICK:
                    begin
                        if (run_en_reg)
                        begin
                            qleft_next = qdec;
                            if (qdec == '0 && preempt_en_reg)
                            begin
                                pre_cnt_next = pre_cnt_reg + CNT32_W'(1);
                                state_next   = S_SCHED;
                            end
                        end
                    end
                    OP_YIELD:
                    begin
                        if (run_en_reg)
                        begin
                            yld_cnt_next = yld_cnt_reg + CNT32_W'(1);
                            state_next   = S_SCHED;
                        end
                    end
                    OP_READY:
                    begin
                        sleep_next[pid_reg] = 1'b0;
                        rdy_cmd = '{valid: 1'b1, op: LOP_PUSH, id: pid_reg};
                        if (rdy_rsp.len == LEN_W'(MAX_PROCS))
                            ev_drop_next = 1'b1;
                    end
                    OP_BLOCK:
                    begin
                        rdy_cmd    = '{valid: 1'b1, op: LOP_REMOVE, id: pid_reg};
                        blk_cmd    = '{valid: 1'b1, op: LOP_REMOVE, id: pid_reg};
                        state_next = S_BLK;
                    end
                    OP_UNBLOCK:
                    begin
                        blk_cmd    = '{valid: 1'b1, op: LOP_REMOVE, id: pid_reg};
                        state_next = S_UNB;
                    end
                    default: ;
                endcase
            end
            S_BLK:
            begin
                if (!rdy_rsp.busy && !blk_rsp.busy)
                begin
                    sleep_next[pid_reg] = 1'b1;
                    blk_cmd = '{valid: 1'b1, op: LOP_PUSH, id: pid_reg};
                    if (blk_rsp.len == LEN_W'(MAX_PROCS))
                        ev_drop_next = 1'b1;
                    if (run_valid_reg && run_id_reg == pid_reg)
                        state_next = S_SCHED;
                    else
                        state_next = S_OUT;
                end
            end
            S_UNB:
            begin
                if (!blk_rsp.busy)
                begin
                    sleep_next[pid_reg] = 1'b0;
                    rdy_cmd = '{valid: 1'b1, op: LOP_PUSH, id: pid_reg};
                    if (rdy_rsp.len == LEN_W'(MAX_PROCS))
                        ev_drop_next = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_SCHED:
            begin
                if (!run_en_reg)
                    state_next = S_OUT;
                else if (rdy_rsp.len != '0)
                begin
                    rdy_cmd    = '{valid: 1'b1, op: LOP_POP, id: pid_reg};
                    state_next = S_POPW;
                end
                else if (idle_valid_reg)
                begin
                    nxt_next   = idle_id_reg;
                    state_next = S_SW;
                end
                else
                    state_next = S_OUT;
            end
            S_POPW:
            begin
                if (!rdy_rsp.busy)
                begin
                    nxt_next   = rdy_rsp.data;
                    state_next = S_SW;
                end
            end
            S_SW:
            begin
                state_next = S_OUT;
                // same process chosen: entry consumed, no switch
                if (!(run_valid_reg && nxt_reg == run_id_reg))
                begin
                    ev_pid_next = run_id_reg;
                    ev_pv_next  = run_valid_reg;
                    if (run_valid_reg && !sleep_reg[run_id_reg])
                    begin
                        rdy_cmd = '{valid: 1'b1, op: LOP_PUSH, id: run_id_reg};
                        if (rdy_rsp.len == LEN_W'(MAX_PROCS))
                            ev_drop_next = 1'b1;
                    end
                    sleep_next[nxt_reg] = 1'b0;
                    run_id_next    = nxt_reg;
                    run_valid_next = 1'b1;
                    sw_cnt_next    = sw_cnt_reg + CNT32_W'(1);
                    qleft_next     = quantum_reg;
                    ev_sw_next     = 1'b1;
                end
            end
            S_OUT:
            begin
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next = {
                        5'd0,
                        ev_drop_reg,
                        yld_cnt_reg,
                        pre_cnt_reg,
                        sw_cnt_reg,
                        blk_rsp.len,
                        rdy_rsp.len,
                        ev_sw_reg && (run_id_reg != '0),
                        ev_pv_reg,
                        ev_pid_reg,
                        ev_sw_reg,
                        run_valid_reg,
                        run_id_reg
                    };
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sleep_reg     <= '0;
            run_id_reg    <= '0;
            run_valid_reg <= 1'b0;
            qleft_reg     <= '0;
            sw_cnt_reg    <= '0;
            pre_cnt_reg   <= '0;
            yld_cnt_reg   <= '0;
            ev_drop_reg   <= 1'b0;
            ev_sw_reg     <= 1'b0;
            ev_pv_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sleep_reg     <= sleep_next;
            run_id_reg    <= run_id_next;
            run_valid_reg <= run_valid_next;
            qleft_reg     <= qleft_next;
            sw_cnt_reg    <= sw_cnt_next;
            pre_cnt_reg   <= pre_cnt_next;
            yld_cnt_reg   <= yld_cnt_next;
            ev_drop_reg   <= ev_drop_next;
            ev_sw_reg     <= ev_sw_next;
            ev_pv_reg     <= ev_pv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        pid_reg      <= pid_next;
        nxt_reg      <= nxt_next;
        ev_pid_reg   <= ev_pid_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
`default_nettype wire

// ----- rtl/rrts_checker.sv -----
// Port-level checks for the round robin task scheduler, bound to the top level.
// Uses the assertion macros from round_robin_task_scheduler_defines.svh.
`default_nettype none
`include "round_robin_task_scheduler_defines.svh"
module rrts_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic [7:0]   s_axis_tdata,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [127:0] m_axis_tdata,
    input wire logic         psel,
    input wire logic         penable,
    input wire logic         pwrite,
    input wire logic [4:0]   paddr,
    input wire logic [31:0]  pwdata,
    input wire logic [31:0]  prdata,
    input wire logic         pready
);
    // a stalled result stays offered
    `RRTS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    // no switch means no previous process and no user entry
    `RRTS_ASSERT_IMPL(a_noswitch, m_axis_tvalid && !m_axis_tdata[6],
        m_axis_tdata[11:7] == 5'd0 && !m_axis_tdata[12] && !m_axis_tdata[13])
    // a switch always lands on a running process
    `RRTS_ASSERT_IMPL(a_switch_runs, m_axis_tvalid && m_axis_tdata[6], m_axis_tdata[5])
    // queue occupancies never exceed the process count
    `RRTS_ASSERT_IMPL(a_len_bound, m_axis_tvalid,
        m_axis_tdata[19:14] <= 6'd32 && m_axis_tdata[25:20] <= 6'd32)
endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (.*);
`default_nettype wire

// ----- verif/round_robin_task_scheduler_checker.sv -----
// Result checker for the round robin task scheduler: watches both streams,
// predicts each result from its own scheduler state and counts mismatches.
// Depends on rrts_pkg; config mirror is fed by the testbench top via cfg_* inputs.
`timescale 1ns / 1ps
module round_robin_task_scheduler_checker
    import rrts_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [127:0] m_axis_tdata,
    input  wire logic [15:0]  cfg_quantum,
    input  wire logic         cfg_preempt,
    input  wire logic         cfg_run,
    input  wire logic [4:0]   cfg_idle_id,
    input  wire logic         cfg_idle_valid,
    output int                fail_count,
    output int                pending_results
);

    typedef struct packed {
        logic        dropped;
        logic [31:0] yields;
        logic [31:0] preempts;
        logic [31:0] switches;
        logic [5:0]  blocked_n;
        logic [5:0]  ready_n;
        logic        enter_user;
        logic        prev_valid;
        logic [4:0]  prev_id;
        logic        switched;
        logic        cur_valid;
        logic [4:0]  cur_id;
    } sched_result_t;

    logic [4:0]    ready_q[$];
    logic [4:0]    blocked_q[$];
    logic [31:0]   asleep;
    logic [4:0]    run_id;
    logic          run_valid;
    logic [15:0]   quantum_left;
    logic [31:0]   n_switch, n_preempt, n_yield;
    sched_result_t expected_q[$];
    logic          ev_drop, ev_switch, ev_prev_valid;
    logic [4:0]    ev_prev_id;

    assign pending_results = expected_q.size();

    function automatic void enqueue_ready(logic [4:0] id);
        asleep[id] = 1'b0;
        if (ready_q.size() >= MAX_PROCS) ev_drop = 1'b1;
        else ready_q.push_back(id);
    endfunction

    function automatic void drop_first(ref logic [4:0] q[$], input logic [4:0] id);
        for (int i = 0; i < q.size(); i++)
        begin
            if (q[i] == id)
            begin
                q.delete(i);
                return;
            end
        end
    endfunction

    function automatic void pick_next();
        logic [4:0] nxt;
        if (!cfg_run) return;
        if (ready_q.size() > 0) nxt = ready_q.pop_front();
        else if (cfg_idle_valid) nxt = cfg_idle_id;
        else return;
        if (run_valid && nxt == run_id) return;
        ev_prev_id    = run_id;
        ev_prev_valid = run_valid;
        if (run_valid && !asleep[run_id]) enqueue_ready(run_id);
        asleep[nxt]  = 1'b0;
        run_id       = nxt;
        run_valid    = 1'b1;
        n_switch     = n_switch + 32'(1);
        quantum_left = cfg_quantum;
        ev_switch    = 1'b1;
    endfunction

    function automatic sched_result_t apply_event(logic [2:0] op, logic [4:0] pid);
        sched_result_t r;
        ev_drop = 1'b0; ev_switch = 1'b0; ev_prev_id = '0; ev_prev_valid = 1'b0;
        case (op)
            OP_TICK:
                if (cfg_run)
                begin
                    if (quantum_left > 0) quantum_left = quantum_left - 16'(1);
                    if (quantum_left == 0 && cfg_preempt)
                    begin
                        n_preempt = n_preempt + 32'(1);
                        pick_next();
                    end
                end
            OP_YIELD:
                if (cfg_run)
                begin
                    n_yield = n_yield + 32'(1);
                    pick_next();
                end
            OP_READY: enqueue_ready(pid);
            OP_BLOCK:
            begin
                drop_first(ready_q, pid);
                drop_first(blocked_q, pid);
                asleep[pid] = 1'b1;
                if (blocked_q.size() >= MAX_PROCS) ev_drop = 1'b1;
                else blocked_q.push_back(pid);
                if (run_valid && run_id == pid) pick_next();
            end
            OP_UNBLOCK:
            begin
                drop_first(blocked_q, pid);
                enqueue_ready(pid);
            end
            default: ;
        endcase
        r.cur_id     = run_id;
        r.cur_valid  = run_valid;
        r.switched   = ev_switch;
        r.prev_id    = ev_prev_id;
        r.prev_valid = ev_prev_valid;
        r.enter_user = ev_switch && run_id != 0;
        r.ready_n    = 6'(ready_q.size());
        r.blocked_n  = 6'(blocked_q.size());
        r.switches   = n_switch;
        r.preempts   = n_preempt;
        r.yields     = n_yield;
        r.dropped    = ev_drop;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t want, got;
        if (!rst_n)
        begin
            ready_q.delete(); blocked_q.delete(); expected_q.delete();
            asleep = '0; run_id = '0; run_valid = 1'b0; quantum_left = '0;
            n_switch = '0; n_preempt = '0; n_yield = '0; fail_count = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[122:0];
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: expected none actual %h", got);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want || m_axis_tdata[127:123] !== 5'd0)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result mismatch: expected %h actual %h", want,
                                m_axis_tdata);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(apply_event(s_axis_tdata[2:0], s_axis_tdata[7:3]));
        end
    end

endmodule

// ----- verif/round_robin_task_scheduler_tb.sv -----
// Testbench top for the round robin task scheduler: clock, reset, APB setup,
// event stimulus, random stalls and the verdict. Depends on rrts_pkg and the checker.
`timescale 1ns / 1ps
module round_robin_task_scheduler_tb;
    import rrts_pkg::*;

    logic         clk = 0;
    logic         rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [127:0] m_axis_tdata;
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [4:0]   paddr = 0;
    logic [31:0]  pwdata = 0;
    logic [31:0]  prdata;
    logic         pready;
    logic [15:0]  cfg_quantum = 10;
    logic         cfg_preempt = 1, cfg_run = 0, cfg_idle_valid = 0;
    logic [4:0]   cfg_idle_id = 0;
    int           fail_count, pending_results;
    int           idle_cycles = 0;

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    round_robin_task_scheduler i_dut (.*);

    round_robin_task_scheduler_checker i_checker (.*);

    // receiver stalls drawn per result; hold ready high when no stall is drawn
    initial
    begin
        int hold;
        forever
        begin
            hold = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
            if (hold != 0)
            begin
                m_axis_tready <= 0;
                repeat (hold) @(posedge clk);
            end
            m_axis_tready <= 1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] index, logic [31:0] value);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= {index, 2'b00}; pwdata <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (index)
            REG_QUANTUM:    cfg_quantum = value[15:0];
            REG_PREEMPT:    cfg_preempt = value[0];
            REG_RUN:        cfg_run = value[0];
            REG_IDLE_ID:    cfg_idle_id = value[4:0];
            REG_IDLE_VALID: cfg_idle_valid = value[0];
            default: ;
        endcase
    endtask

    // valid stays high into the next request when no gap is drawn
    task automatic send_request(logic [2:0] op, logic [4:0] pid, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15));
        if (gap != 0)
        begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {pid, op};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (pending_results != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // mostly scheduling events over a small ID set so queues collide and repeat
    task automatic random_events(int n, int id_span);
        int k;
        logic [4:0] pid;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 99);
            pid = 5'($urandom_range(0, id_span));
            if (k < 25) send_request(OP_TICK, 5'($urandom));
            else if (k < 40) send_request(OP_YIELD, 5'($urandom));
            else if (k < 65) send_request(OP_READY, pid);
            else if (k < 80) send_request(OP_BLOCK, pid);
            else if (k < 96) send_request(OP_UNBLOCK, pid);
            else send_request(3'($urandom_range(5, 7)), 5'($urandom));
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: idle scheduler, extremes of IDs, unknown ops
        send_request(OP_TICK, 0);
        send_request(OP_YIELD, 31);
        send_request(OP_READY, 31);
        send_request(OP_READY, 0);
        send_request(OP_BLOCK, 31);
        send_request(OP_UNBLOCK, 31);
        send_request(3'd5, 5'd21);
        send_request(3'd7, 5'd10);
        drain();
        write_reg(REG_QUANTUM, 2);
        write_reg(REG_RUN, 1);
        // yields switch among processes readied earlier, blocking the running one, nothing to run, preemption
        send_request(OP_YIELD, 0);
        send_request(OP_YIELD, 0);
        send_request(OP_YIELD, 0);
        send_request(OP_BLOCK, 0);
        send_request(OP_YIELD, 0);
        send_request(OP_READY, 7);
        send_request(OP_READY, 7);
        send_request(OP_TICK, 0);
        send_request(OP_TICK, 0);
        send_request(OP_TICK, 0);
        send_request(OP_BLOCK, 7);
        send_request(OP_UNBLOCK, 7);
        drain();
        write_reg(REG_IDLE_ID, 31);
        write_reg(REG_IDLE_VALID, 1);
        send_request(OP_YIELD, 0);
        send_request(OP_YIELD, 0);
        send_request(OP_BLOCK, 31);
        // fill the ready queue past its depth
        for (int i = 0; i < 34; i++) send_request(OP_READY, i[4:0], 1);
        for (int i = 0; i < 34; i++) send_request(OP_BLOCK, i[4:0], 1);
        drain();

        write_reg(REG_QUANTUM, 0);
        write_reg(REG_PREEMPT, 1);
        random_events(250, 7);
        drain();
        write_reg(REG_QUANTUM, 16'hFFFF);
        write_reg(REG_IDLE_ID, 0);
        random_events(200, 31);
        drain();
        write_reg(REG_PREEMPT, 0);
        write_reg(REG_QUANTUM, 3);
        write_reg(REG_IDLE_VALID, 0);
        random_events(250, 3);
        drain();
        write_reg(REG_PREEMPT, 1);
        write_reg(REG_QUANTUM, 1);
        write_reg(REG_IDLE_ID, 5);
        write_reg(REG_IDLE_VALID, 1);
        random_events(150, 15);
        drain();
        write_reg(REG_RUN, 0);
        random_events(50, 31);
        drain();

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
